@@ hdl/box_smooth_3x3_clamped_defines.svh @@
// Assertion macros for the 3x3 box smoothing filter.
`ifndef BOX_SMOOTH_3X3_CLAMPED_DEFINES_SVH
`define BOX_SMOOTH_3X3_CLAMPED_DEFINES_SVH

`ifndef SYNTH

// Property checked on every rising clock edge outside reset.
`define BSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be true outside reset.
`define BSC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition");

`else

`define BSC_ASSERT(lbl, prop)
`define BSC_NEVER(lbl, cond)

`endif

`endif

@@ hdl/bsc_pkg.sv @@
// Package for the 3x3 box smoothing filter: sizes, codes and result type.
`default_nettype none

package bsc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W      = 11;

	// Command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// Register indexes
	localparam logic CFG_MAP_WIDTH  = 1'b0;
	localparam logic CFG_MAP_HEIGHT = 1'b1;

	// Divide by nine: floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT for x < 2**20
	localparam int          DIV9_SHIFT = 23;
	localparam logic [19:0] DIV9_MUL   = 20'd932068;

	// Result queue depth
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [15:0] value;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        done;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/box_smooth_3x3_clamped.sv @@
// Top level of the streaming 3x3 box smoothing filter with edge clamping.
`default_nettype none
`include "box_smooth_3x3_clamped_defines.svh"

// Streaming 3x3 mean filter over a raster-order height map. One input
// transaction is taken per clock; the two line buffers are single-write,
// single-read memories read at the column address of each item, so nothing
// in the loop limits the rate below one item a cycle. A result passes through
// stage 1, stage 2 and the result queue before it shows on the output. The
// last column of a row can yield two results from one item, so with the output
// taking one result a cycle the input is held off only when the eight-entry
// result queue would otherwise overrun. Results lag input by one row and one
// column; after the last sample of the frame, send flush commands (one per
// column) to drain the final row. Samples while draining and flushes outside
// draining are dropped. A write to map_width or map_height takes effect at
// once, mid-frame too; write them only while no transaction is in flight.
module box_smooth_3x3_clamped
	import bsc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              command,
	input  wire logic [15:0]       height_value,
	// Output channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            smoothed_value,
	output logic [9:0]             out_row,
	output logic [9:0]             out_col,
	output logic                   frame_done,
	// Configuration channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// Configuration registers
	logic [CFG_W-1:0] map_width_q, map_height_q;

	// Raster position
	logic [ADDR_W-1:0] in_row_q, in_col_q, drain_col_q;
	logic              draining_q;

	// Line buffers
	logic [15:0] older_mem [MAX_WIDTH];
	logic [15:0] newer_mem [MAX_WIDTH];

	// Stage 1: memory read data and item control
	logic              valid_s1, we_s1, emit_s1, last_s1, final_s1;
	logic              use_older_s1, bot_mid_s1, fwd_s1;
	logic [ADDR_W-1:0] col_s1, row_s1;
	logic [15:0]       v_s1, older_rd_s1, newer_rd_s1, fwd_older_s1, fwd_newer_s1;

	// Column sums of the window (column c-1 and c-2)
	logic [17:0] psum1_q, psum2_q;

	// Stage 2: neighborhood sums
	logic              a_vld_s2, b_vld_s2, b_done_s2;
	logic [19:0]       sum_a_s2, sum_b_s2;
	logic [ADDR_W-1:0] col_s2, row_s2;

	// Result queue
	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	// ---------------------------------------------------------------
	// Stage 0: size clamping, item decode, address
	// ---------------------------------------------------------------
	logic [CFG_W-1:0]  w_eff, h_eff, w_last, h_last;
	logic              in_fire, smp_act, fl_act, act, last0, row_last;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		if (map_width_q == '0)
			w_eff = CFG_W'(1);
		else if (map_width_q > CFG_W'(MAX_WIDTH))
			w_eff = CFG_W'(MAX_WIDTH);
		else
			w_eff = map_width_q;
		if (map_height_q == '0)
			h_eff = CFG_W'(1);
		else if (map_height_q > CFG_W'(MAX_HEIGHT))
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = map_height_q;
	end

	assign w_last   = w_eff - CFG_W'(1);
	assign h_last   = h_eff - CFG_W'(1);
	assign in_fire  = in_valid && in_ready;
	assign smp_act  = in_fire && (command == CMD_SAMPLE) && !draining_q;
	assign fl_act   = in_fire && (command == CMD_FLUSH) && draining_q;
	assign act      = smp_act || fl_act;
	assign rd_addr  = (command == CMD_SAMPLE) ? in_col_q : drain_col_q;
	assign last0    = CFG_W'(rd_addr) >= w_last;
	assign row_last = CFG_W'(in_row_q) >= h_last;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= CFG_W'(MAX_WIDTH);
			map_height_q <= CFG_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			drain_col_q <= '0;
			draining_q  <= 1'b0;
		end else if (smp_act) begin
			if (last0) begin
				in_col_q <= '0;
				if (row_last) begin
					draining_q  <= 1'b1;
					drain_col_q <= '0;
				end else begin
					in_row_q <= in_row_q + ADDR_W'(1);
				end
			end else begin
				in_col_q <= in_col_q + ADDR_W'(1);
			end
		end else if (fl_act) begin
			if (last0) begin
				draining_q  <= 1'b0;
				drain_col_q <= '0;
				in_row_q    <= '0;
				in_col_q    <= '0;
			end else begin
				drain_col_q <= drain_col_q + ADDR_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: window column assembly and sums
	// ---------------------------------------------------------------
	logic [15:0] newer_c, older_c, mid_c, top_c, bot_c;
	logic [17:0] cur, p1, p2;
	logic [19:0] sum_a, sum_b;

	always_comb begin
		newer_c = fwd_s1 ? fwd_newer_s1 : newer_rd_s1;
		older_c = fwd_s1 ? fwd_older_s1 : older_rd_s1;
		mid_c   = newer_c;
		top_c   = use_older_s1 ? older_c : mid_c;
		bot_c   = bot_mid_s1 ? mid_c : v_s1;
		cur     = 18'(top_c) + 18'(mid_c) + 18'(bot_c);
		// first column replicates itself to the left
		p1      = (col_s1 == '0) ? cur : psum1_q;
		p2      = (col_s1 == '0) ? cur : psum2_q;
		sum_a   = 20'(p2) + 20'(p1) + 20'(cur);
		sum_b   = 20'(p1) + {1'b0, cur, 1'b0};
	end

	// Line buffer ports: read at accept, write back from stage 1
	always_ff @(posedge clk) begin
		if (act) begin
			older_rd_s1 <= older_mem[rd_addr];
			newer_rd_s1 <= newer_mem[rd_addr];
		end
		if (valid_s1 && we_s1) begin
			older_mem[col_s1] <= mid_c;
			newer_mem[col_s1] <= v_s1;
		end
	end

	// Stage 1 payload; forward the write of stage 1 to a read of the same column
	always_ff @(posedge clk) begin
		if (act) begin
			col_s1       <= rd_addr;
			last_s1      <= last0;
			v_s1         <= height_value;
			we_s1        <= smp_act;
			emit_s1      <= fl_act || (in_row_q != '0);
			row_s1       <= smp_act ? (in_row_q - ADDR_W'(1)) : in_row_q;
			final_s1     <= fl_act && last0;
			use_older_s1 <= smp_act ? (in_row_q >= ADDR_W'(2)) : (in_row_q != '0);
			bot_mid_s1   <= fl_act;
			fwd_s1       <= valid_s1 && we_s1 && (col_s1 == rd_addr);
			fwd_older_s1 <= mid_c;
			fwd_newer_s1 <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= act;
		end
	end

	// Window column sums advance on each fed column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum1_q <= '0;
			psum2_q <= '0;
		end else if (valid_s1 && emit_s1) begin
			psum2_q <= p1;
			psum1_q <= cur;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s2 <= 1'b0;
			b_vld_s2 <= 1'b0;
		end else begin
			a_vld_s2 <= valid_s1 && emit_s1 && (col_s1 != '0);
			b_vld_s2 <= valid_s1 && emit_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_a_s2  <= sum_a;
		sum_b_s2  <= sum_b;
		col_s2    <= col_s1;
		row_s2    <= row_s1;
		b_done_s2 <= final_s1;
	end

	// ---------------------------------------------------------------
	// Stage 2: rounded divide by nine, push into result queue
	// ---------------------------------------------------------------
	logic [39:0] prod_a, prod_b;
	res_t        res_a, res_b;
	logic [1:0]  n_s2;
	logic        pop;

	always_comb begin
		prod_a      = 40'(sum_a_s2 + 20'd4) * 40'(DIV9_MUL);
		prod_b      = 40'(sum_b_s2 + 20'd4) * 40'(DIV9_MUL);
		res_a.value = prod_a[DIV9_SHIFT +: 16];
		res_a.row   = 10'(row_s2);
		res_a.col   = 10'(col_s2 - ADDR_W'(1));
		res_a.done  = 1'b0;
		res_b.value = prod_b[DIV9_SHIFT +: 16];
		res_b.row   = 10'(row_s2);
		res_b.col   = 10'(col_s2);
		res_b.done  = b_done_s2;
	end

	assign n_s2 = {1'b0, a_vld_s2} + {1'b0, b_vld_s2};
	assign pop  = out_valid && out_ready;

	// Room for everything in flight plus two results of a new item
	assign in_ready = (5'(count_q) + {3'b0, valid_s1, 1'b0} + 5'(n_s2) + 5'd2)
		<= 5'(FIFO_DEPTH);

	// Queue storage
	always_ff @(posedge clk) begin
		if (a_vld_s2)
			fifo_q[wr_ptr_q] <= res_a;
		if (b_vld_s2) begin
			if (a_vld_s2)
				fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res_b;
			else
				fifo_q[wr_ptr_q] <= res_b;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_s2);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(n_s2) - (FIFO_AW+1)'(pop);
		end
	end

	assign out_valid      = (count_q != '0);
	assign smoothed_value = fifo_q[rd_ptr_q].value;
	assign out_row        = fifo_q[rd_ptr_q].row;
	assign out_col        = fifo_q[rd_ptr_q].col;
	assign frame_done     = fifo_q[rd_ptr_q].done;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`BSC_NEVER(a_fifo_overrun, (5'(count_q) + 5'(n_s2)) > 5'(FIFO_DEPTH))
	`BSC_ASSERT(a_drain_at_row_start, draining_q |-> (in_col_q == '0))
	`BSC_ASSERT(a_drain_col_idle, !draining_q |-> (drain_col_q == '0))
	`BSC_ASSERT(a_fwd_only_sample, (valid_s1 && fwd_s1) |-> $past(we_s1))

endmodule

`default_nettype wire

@@ tb/tb_box_smooth_3x3_clamped.sv @@
// Self-checking testbench for the streaming 3x3 clamped box smoothing filter.
`timescale 1ns / 100ps

module tb_box_smooth_3x3_clamped
	import bsc_pkg::*;
();

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned QUIET_CYCLES = 16;
	localparam int unsigned NOISE_PCT    = 8;

	typedef struct packed {
		logic        cmd;
		logic [15:0] value;
	} stream_item_t;

	// DUT connections, inputs driven to known values from time zero
	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic              command        = CMD_SAMPLE;
	logic [15:0]       height_value   = 16'd0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [15:0]       smoothed_value;
	logic [9:0]        out_row;
	logic [9:0]        out_col;
	logic              frame_done;
	logic              cfg_valid      = 1'b0;
	logic              cfg_ready;
	logic              cfg_index      = CFG_MAP_WIDTH;
	logic [CFG_W-1:0]  cfg_data       = '0;

	// Stimulus and expected results
	stream_item_t feed_q [$];
	res_t         expected_means [$];
	stream_item_t next_item;
	res_t         want;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  stim_count    = 0;
	int unsigned  fail_count    = 0;
	int unsigned  idle_cycles   = 0;

	// Filter state mirrored by the predictor
	logic [15:0]      row_m2_buf [MAX_WIDTH];
	logic [15:0]      row_m1_buf [MAX_WIDTH];
	logic [15:0]      win_prev1 [3] = '{16'd0, 16'd0, 16'd0};
	logic [15:0]      win_prev2 [3] = '{16'd0, 16'd0, 16'd0};
	int unsigned      row_pos   = 0;
	int unsigned      col_pos   = 0;
	int unsigned      drain_pos = 0;
	bit               in_drain  = 1'b0;
	logic [CFG_W-1:0] width_reg  = 11'd1024;
	logic [CFG_W-1:0] height_reg = 11'd1024;

	box_smooth_3x3_clamped dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.height_value   (height_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.out_row        (out_row),
		.out_col        (out_col),
		.frame_done     (frame_done),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register values outside [1, cap] act as the nearest bound
	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned cap);
		if (v == 0)
			return 1;
		if (v > cap)
			return cap;
		return 32'(v);
	endfunction

	// Rounded mean of nine samples
	function automatic void push_mean(int unsigned sum, int unsigned row, int unsigned col,
			bit fin);
		res_t r;
		r.value = 16'((sum + 4) / 9);
		r.row   = 10'(row);
		r.col   = 10'(col);
		r.done  = fin;
		expected_means.push_back(r);
	endfunction

	// One window column enters; left edge replicates itself into both history columns
	function automatic void shift_column(int unsigned col, logic [15:0] t, logic [15:0] m,
			logic [15:0] b, bit last, int unsigned row, bit fin);
		int unsigned cur_sum;
		int unsigned sum1;
		int unsigned sum2;
		cur_sum = 32'(t) + 32'(m) + 32'(b);
		if (col == 0) begin
			win_prev1 = '{t, m, b};
			win_prev2 = '{t, m, b};
		end
		sum1 = 32'(win_prev1[0]) + 32'(win_prev1[1]) + 32'(win_prev1[2]);
		sum2 = 32'(win_prev2[0]) + 32'(win_prev2[1]) + 32'(win_prev2[2]);
		if (col >= 1)
			push_mean(sum2 + sum1 + cur_sum, row, col - 1, 1'b0);
		// right edge: current column stands in for the missing one
		if (last)
			push_mean(sum1 + 2 * cur_sum, row, col, fin);
		win_prev2 = win_prev1;
		win_prev1 = '{t, m, b};
	endfunction

	// Advance the filter by one accepted input transaction
	function automatic void advance_filter(logic cmd, logic [15:0] v);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		bit          last;
		logic [15:0] mid;
		logic [15:0] top;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (cmd == CMD_SAMPLE) begin
			// samples are dropped while the last row drains
			if (in_drain || col_pos >= MAX_WIDTH)
				return;
			col  = col_pos;
			row  = row_pos;
			last = (col >= w - 1);
			mid  = row_m1_buf[col];
			top  = (row >= 2) ? row_m2_buf[col] : mid;
			if (row >= 1)
				shift_column(col, top, mid, v, last, row - 1, 1'b0);
			row_m2_buf[col] = row_m1_buf[col];
			row_m1_buf[col] = v;
			if (last) begin
				col_pos = 0;
				if (row >= h - 1) begin
					in_drain  = 1'b1;
					drain_pos = 0;
				end else begin
					row_pos = row + 1;
				end
			end else begin
				col_pos = col + 1;
			end
		end else begin
			// flushes only count once the frame is complete
			if (!in_drain || drain_pos >= MAX_WIDTH)
				return;
			col  = drain_pos;
			last = (col >= w - 1);
			mid  = row_m1_buf[col];
			top  = (row_pos >= 1) ? row_m2_buf[col] : mid;
			shift_column(col, top, mid, mid, last, row_pos, last);
			if (last) begin
				in_drain  = 1'b0;
				drain_pos = 0;
				row_pos   = 0;
				col_pos   = 0;
			end else begin
				drain_pos = col + 1;
			end
		end
	endfunction

	function automatic void queue_item(logic cmd, logic [15:0] v);
		stream_item_t it;
		it.cmd   = cmd;
		it.value = v;
		feed_q.push_back(it);
	endfunction

	// Heights lean toward the extremes
	function automatic logic [15:0] pick_height();
		case ($urandom_range(0, 7))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			default: begin
				return 16'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// Full raster frame plus drain, with dropped transactions mixed in
	task automatic queue_frame(input int unsigned w, input int unsigned h,
			input int unsigned noise_pct);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if ($urandom_range(0, 99) < noise_pct)
					queue_item(CMD_FLUSH, 16'($urandom_range(0, 65535)));
				queue_item(CMD_SAMPLE, pick_height());
				stim_count++;
			end
		end
		for (int d = 0; d < w; d++) begin
			if ($urandom_range(0, 99) < noise_pct)
				queue_item(CMD_SAMPLE, pick_height());
			queue_item(CMD_FLUSH, 16'($urandom_range(0, 65535)));
			stim_count++;
		end
	endtask

	// Block idle: no pending stimulus, nothing in flight, nothing outstanding
	task automatic wait_until_quiet();
		do @(posedge clk);
		while (feed_q.size() != 0 || in_valid || expected_means.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAP_WIDTH)
			width_reg = val;
		else
			height_reg = val;
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(CFG_MAP_WIDTH, w);
		write_reg(CFG_MAP_HEIGHT, h);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int unsigned frames, input int unsigned noise_pct);
		wait_until_quiet();
		set_size(w, h);
		repeat (frames)
			queue_frame(clamp_dim(w, MAX_WIDTH), clamp_dim(h, MAX_HEIGHT), noise_pct);
	endtask

	// Small random sizes, register extremes now and then
	task automatic run_small_phases(input int unsigned target);
		int unsigned      start;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		start = stim_count;
		while (stim_count < start + target) begin
			case ($urandom_range(0, 9))
				0: w = 11'd0;
				1: w = 11'd1;
				2: w = 11'd2;
				3: w = 11'd3;
				default: w = 11'($urandom_range(4, 24));
			endcase
			case ($urandom_range(0, 7))
				0: h = 11'd0;
				1: h = 11'd1;
				2: h = 11'd2;
				default: h = 11'($urandom_range(3, 10));
			endcase
			run_phase(w, h, $urandom_range(1, 3), NOISE_PCT);
		end
	endtask

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			command      <= CMD_SAMPLE;
			height_value <= 16'd0;
		end else begin
			if (in_valid && in_ready)
				advance_filter(command, height_value);
			if (!in_valid || in_ready) begin
				if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = feed_q.pop_front();
					in_valid     <= 1'b1;
					command      <= next_item.cmd;
					height_value <= next_item.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_means.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result value %0d row %0d col %0d done %0d",
						$time, smoothed_value, out_row, out_col, frame_done);
			end else begin
				want = expected_means.pop_front();
				if (smoothed_value !== want.value || out_row !== want.row ||
						out_col !== want.col || frame_done !== want.done) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"%0t: expected value %0d row %0d col %0d done %0d, ",
							"got value %0d row %0d col %0d done %0d"}, $time,
							want.value, want.row, want.col, want.done,
							smoothed_value, out_row, out_col, frame_done);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Test sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 66;

		// 3x2 at full scale; a flush before the frame and a sample during drain are dropped
		wait_until_quiet();
		set_size(11'd3, 11'd2);
		queue_item(CMD_FLUSH, 16'hFFFF);
		repeat (6) queue_item(CMD_SAMPLE, 16'hFFFF);
		queue_item(CMD_SAMPLE, 16'h0000);
		repeat (3) queue_item(CMD_FLUSH, 16'h0000);

		// single pixel frame
		wait_until_quiet();
		set_size(11'd1, 11'd1);
		queue_item(CMD_SAMPLE, 16'h0000);
		queue_item(CMD_FLUSH, 16'hFFFF);

		// rounding around the half step
		wait_until_quiet();
		set_size(11'd2, 11'd3);
		queue_item(CMD_SAMPLE, 16'd1);
		queue_item(CMD_SAMPLE, 16'd4);
		queue_item(CMD_SAMPLE, 16'd0);
		queue_item(CMD_SAMPLE, 16'd5);
		queue_item(CMD_SAMPLE, 16'hFFFF);
		queue_item(CMD_SAMPLE, 16'd0);
		repeat (2) queue_item(CMD_FLUSH, 16'h5A5A);

		// width above the maximum acts as the maximum; shrinking it mid-row ends the row
		wait_until_quiet();
		set_size(11'd2047, 11'd1);
		repeat (5) queue_item(CMD_SAMPLE, pick_height());
		wait_until_quiet();
		write_reg(CFG_MAP_WIDTH, 11'd3);
		queue_item(CMD_SAMPLE, pick_height());
		repeat (3) queue_item(CMD_FLUSH, 16'h0000);

		// height above the maximum acts as the maximum; shrinking it mid-frame ends the frame
		wait_until_quiet();
		set_size(11'd2, 11'd2047);
		repeat (6) queue_item(CMD_SAMPLE, pick_height());
		wait_until_quiet();
		write_reg(CFG_MAP_HEIGHT, 11'd2);
		repeat (2) queue_item(CMD_SAMPLE, pick_height());
		repeat (2) queue_item(CMD_FLUSH, 16'h0000);

		// random part: sender mostly busy, receiver stalls often
		run_small_phases(130);

		// sender gaps, receiver mostly ready
		send_idle_pct = 66;
		recv_idle_pct = 22;
		run_small_phases(130);

		// back to back
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_small_phases(120);

		wait_until_quiet();
		if (fail_count == 0 && expected_means.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ box_smooth_3x3_clamped.f @@
+incdir+hdl
hdl/bsc_pkg.sv
hdl/box_smooth_3x3_clamped.sv
tb/tb_box_smooth_3x3_clamped.sv
